FILE: hdl/tdt_pkg.sv
// Shared types, constants and codes for the table-driven DFA tokenizer.
package tdt_pkg;

	// Parameter defaults handed to the top level.
	localparam int NUM_STATES_DEF       = 256;
	localparam int TRANSITION_DEPTH_DEF = 4096;
	localparam int TOKEN_BITS_DEF       = 10;

	// Fixed field widths of the stream payload.
	localparam int ACTION_W    = 3;
	localparam int INDEX_W     = 12;
	localparam int VALUE_W     = 13;
	localparam int BYTE_W      = 8;
	localparam int CODE_W      = 10;
	localparam int COUNT_W     = 32;
	localparam int LEN_W       = 16;
	localparam int TDATA_IN_W  = 40;
	localparam int TDATA_OUT_W = 96;

	// Table geometry that does not follow from a parameter.
	localparam int CLASS_COUNT = 256;
	localparam int CLASS_W     = 12;
	localparam int ROW_W       = 12;
	localparam int SUM_W       = 13;

	// Reciprocal division of a transition value by the state count.
	localparam int QUOT_W      = 12;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 24;
	localparam int REM_W       = 29;

	// Result queue geometry.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

	// Request kinds carried on tuser.
	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD_CLASS = 3'd0,
		ACT_LOAD_ROW   = 3'd1,
		ACT_LOAD_TRANS = 3'd2,
		ACT_LOAD_TOKEN = 3'd3,
		ACT_SCAN       = 3'd4
	} action_t;

	// One request after the class lookup stage.
	typedef struct packed {
		action_t             action;
		logic [INDEX_W-1:0]  index;
		logic [VALUE_W-1:0]  value;
		logic [BYTE_W-1:0]   chr;
		logic [QUOT_W-1:0]   quot;
	} item_t;

	// One reported token.
	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] line;
		logic [COUNT_W-1:0] offset;
		logic [LEN_W-1:0]   length;
		logic               last;
	} result_t;

	// Up to two tokens produced by one scanned byte.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

FILE: hdl/tdt_front.sv
// Input stage: request register, class table and quotient estimate.
module tdt_front #(
	parameter int NUM_STATES = tdt_pkg::NUM_STATES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tdt_pkg::ACTION_W-1:0]     s_tuser,   // action
	input  logic [tdt_pkg::TDATA_IN_W-1:0]   s_tdata,   // table_index, table_value, byte_value
	input  logic                             take,
	output logic                             item_valid,
	output tdt_pkg::item_t                   item,
	output logic [tdt_pkg::CLASS_W-1:0]      cls
);
	import tdt_pkg::*;

	localparam int RECIP = (1 << RECIP_SHIFT) / NUM_STATES;
	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
	localparam int PROD_W = QUOT_W + RECIP_W;

	logic [CLASS_W-1:0] class_mem [CLASS_COUNT];

	logic                 item_valid_s1;
	item_t                item_s1;
	logic [CLASS_W-1:0]   cls_s1;
	logic                 accept;
	action_t              act;
	logic [INDEX_W-1:0]   idx;
	logic [VALUE_W-1:0]   val;
	logic [BYTE_W-1:0]    chr;
	logic [PROD_W-1:0]    prod;

	// Field split of the incoming request.
	assign act = action_t'(s_tuser);
	assign idx = s_tdata[INDEX_W-1:0];
	assign val = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
	assign chr = s_tdata[INDEX_W+VALUE_W+BYTE_W-1:INDEX_W+VALUE_W];

	assign s_tready = !item_valid_s1 || take;
	assign accept   = s_tvalid && s_tready;

	// Quotient estimate of the value by the state count, never more than one short.
	assign prod = PROD_W'(val[QUOT_W-1:0]) * PROD_W'(RECIP_V);

	// Class table: loads and lookups both happen in request order here.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (act == ACT_LOAD_CLASS && 32'(idx) < CLASS_COUNT) begin
				class_mem[idx[BYTE_W-1:0]] <= val[CLASS_W-1:0];
			end
			if (act == ACT_SCAN) begin
				cls_s1 <= class_mem[chr];
			end
		end
	end

	// Payload of the waiting request.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action <= act;
			item_s1.index  <= idx;
			item_s1.value  <= val;
			item_s1.chr    <= chr;
			item_s1.quot   <= prod[PROD_W-1:RECIP_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (take) begin
			item_valid_s1 <= 1'b0;
		end
	end

	assign item_valid = item_valid_s1;
	assign item       = item_s1;
	assign cls        = cls_s1;

endmodule

FILE: hdl/tdt_engine.sv
// Scan engine: row, transition and token tables with the state update.
module tdt_engine #(
	parameter int NUM_STATES       = tdt_pkg::NUM_STATES_DEF,
	parameter int TRANSITION_DEPTH = tdt_pkg::TRANSITION_DEPTH_DEF,
	parameter int TOKEN_BITS       = tdt_pkg::TOKEN_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  tdt_pkg::item_t               item,
	input  logic [tdt_pkg::CLASS_W-1:0]  cls,
	input  logic                         room,
	output logic                         take,
	output tdt_pkg::push_t               push
);
	import tdt_pkg::*;

	localparam int SW    = $clog2(NUM_STATES);
	localparam int TAW   = $clog2(TRANSITION_DEPTH);
	localparam int TOK_W = TOKEN_BITS + 1;
	localparam logic [REM_W-1:0] NS_V = REM_W'(NUM_STATES);

	typedef enum logic {PH_ROW, PH_TRANS} phase_t;

	logic [ROW_W-1:0] row_mem   [NUM_STATES];
	logic [TOK_W-1:0] tok_mem   [NUM_STATES];
	logic [SW-1:0]    trans_mem [TRANSITION_DEPTH];

	// Control and architectural state.
	logic              cur_valid_q;
	phase_t            ph_q;
	logic [SW-1:0]     state_q;
	logic [COUNT_W-1:0] line_q, pos_q, start_q, lline_q;

	// Byte in flight and table read data.
	logic [BYTE_W-1:0]  chr_q;
	logic [CLASS_W-1:0] cls_q;
	logic [ROW_W-1:0]   row_rd_q, row0_q;
	logic [TOK_W-1:0]   tok_rd_q, tok0_q;
	logic [SW-1:0]      ta_q, tb_q;
	logic               va_q, vb_q;

	logic [SUM_W-1:0]      sum_a, sum_b;
	logic [SUM_W+TAW-1:0]  ext_a, ext_b;
	logic [INDEX_W+TAW-1:0] ext_ti;
	logic [INDEX_W+SW-1:0]  ext_si;
	logic [VALUE_W+TOKEN_BITS-1:0] ext_tok;
	logic [REM_W-1:0]      rem_raw, rem_fix;
	logic [SW-1:0]         trans_val;
	logic [TOK_W-1:0]      tok_val;
	logic                  issue_trans, finishing, engine_free, scan_take;
	logic [SW-1:0]         y, y0, next_state, st_now;
	logic                  hit, restart, emit1, emit2, nl;
	logic [COUNT_W-1:0]    line_inc, pos_inc, diff;
	result_t               r1, r2;
	logic [TOKEN_BITS+CODE_W-1:0] code1_ext, code2_ext;

	// Engine hand-off: a new request enters when idle or as the current byte retires.
	assign issue_trans = cur_valid_q && ph_q == PH_ROW;
	assign finishing   = cur_valid_q && ph_q == PH_TRANS && room;
	assign engine_free = !cur_valid_q || finishing;
	assign take        = item_valid && engine_free;
	assign scan_take   = take && item.action == ACT_SCAN;

	// Load value shaping.
	assign ext_ti  = (INDEX_W+TAW)'(item.index);
	assign ext_si  = (INDEX_W+SW)'(item.index);
	assign ext_tok = (VALUE_W+TOKEN_BITS)'(item.value);
	assign rem_raw = REM_W'(item.value[QUOT_W-1:0]) - REM_W'(item.quot) * NS_V;
	assign rem_fix = (rem_raw >= NS_V) ? rem_raw - NS_V : rem_raw;
	assign trans_val = (item.value[VALUE_W-1] || item.value == '0) ? '0 : rem_fix[SW-1:0];
	assign tok_val = item.value[VALUE_W-1] ? {1'b1, {TOKEN_BITS{1'b0}}}
	                                      : {1'b0, ext_tok[TOKEN_BITS-1:0]};

	// Transition addresses for the current state and for the start state.
	assign sum_a = SUM_W'(row_rd_q) + SUM_W'(cls_q);
	assign sum_b = SUM_W'(row0_q) + SUM_W'(cls_q);
	assign ext_a = (SUM_W+TAW)'(sum_a);
	assign ext_b = (SUM_W+TAW)'(sum_b);

	// Row and token tables: writes by loads, reads at the state a scan byte starts from.
	always_ff @(posedge clk) begin
		if (take && item.action == ACT_LOAD_ROW && 32'(item.index) < NUM_STATES) begin
			row_mem[ext_si[SW-1:0]] <= item.value[ROW_W-1:0];
		end
		if (take && item.action == ACT_LOAD_TOKEN && 32'(item.index) < NUM_STATES) begin
			tok_mem[ext_si[SW-1:0]] <= tok_val;
		end
		if (scan_take) begin
			row_rd_q <= row_mem[st_now];
			tok_rd_q <= tok_mem[st_now];
		end
	end

	// Start-state row and token kept beside the tables for the restart lookup and the zero-length token.
	always_ff @(posedge clk) begin
		if (take && item.action == ACT_LOAD_ROW && item.index == '0) begin
			row0_q <= item.value[ROW_W-1:0];
		end
		if (take && item.action == ACT_LOAD_TOKEN && item.index == '0) begin
			tok0_q <= tok_val;
		end
	end

	// Transition table: one write port, two read ports.
	always_ff @(posedge clk) begin
		if (take && item.action == ACT_LOAD_TRANS && 32'(item.index) < TRANSITION_DEPTH) begin
			trans_mem[ext_ti[TAW-1:0]] <= trans_val;
		end
		if (issue_trans) begin
			ta_q <= trans_mem[ext_a[TAW-1:0]];
			tb_q <= trans_mem[ext_b[TAW-1:0]];
			va_q <= 32'(sum_a) < TRANSITION_DEPTH;
			vb_q <= 32'(sum_b) < TRANSITION_DEPTH;
		end
	end

	// Byte in flight.
	always_ff @(posedge clk) begin
		if (scan_take) begin
			chr_q <= item.chr;
			cls_q <= cls;
		end
	end

	// Step decision once the transitions are back.
	assign y          = va_q ? ta_q : '0;
	assign y0         = vb_q ? tb_q : '0;
	assign hit        = y != '0;
	assign restart    = !hit && state_q != '0 && y0 != '0;
	assign emit1      = !hit && state_q != '0 && !tok_rd_q[TOKEN_BITS];
	assign emit2      = !hit && !restart && !tok0_q[TOKEN_BITS];
	assign next_state = hit ? y : (restart ? y0 : '0);
	assign st_now     = (cur_valid_q && ph_q == PH_TRANS) ? next_state : state_q;
	assign nl         = chr_q == NEWLINE;
	assign line_inc   = line_q + COUNT_W'(nl);
	assign pos_inc    = pos_q + COUNT_W'(1);
	assign diff       = pos_q - start_q;

	// Token of the lexeme that ends, and the zero-length start-state token.
	assign code1_ext = (TOKEN_BITS+CODE_W)'(tok_rd_q[TOKEN_BITS-1:0]);
	assign code2_ext = (TOKEN_BITS+CODE_W)'(tok0_q[TOKEN_BITS-1:0]);
	always_comb begin
		r1.code   = code1_ext[CODE_W-1:0];
		r1.line   = lline_q;
		r1.offset = start_q;
		r1.length = (diff[COUNT_W-1:LEN_W] != '0) ? '1 : diff[LEN_W-1:0];
		r1.last   = !emit2;
		r2.code   = code2_ext[CODE_W-1:0];
		r2.line   = line_q;
		r2.offset = pos_q;
		r2.length = '0;
		r2.last   = 1'b1;
	end

	always_comb begin
		push.count  = 2'b00;
		push.first  = r1;
		push.second = r2;
		if (finishing) begin
			push.count = {1'b0, emit1} + {1'b0, emit2};
			if (!emit1) begin
				push.first = r2;
			end
		end
	end

	// Sequencer and scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			ph_q        <= PH_ROW;
			state_q     <= '0;
			line_q      <= '0;
			pos_q       <= '0;
			start_q     <= '0;
			lline_q     <= '0;
		end else begin
			if (finishing) begin
				state_q <= next_state;
				line_q  <= line_inc;
				pos_q   <= pos_inc;
				if (!hit) begin
					if (restart) begin
						start_q <= pos_q;
						lline_q <= line_q;
					end else begin
						start_q <= pos_inc;
						lline_q <= line_inc;
					end
				end
			end
			if (scan_take) begin
				cur_valid_q <= 1'b1;
				ph_q        <= PH_ROW;
			end else if (issue_trans) begin
				ph_q <= PH_TRANS;
			end else if (engine_free) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/tdt_resq.sv
// Result queue: takes up to two tokens a cycle while it has room for them, and drives the output stream.
module tdt_resq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tdt_pkg::push_t                   push,
	output logic                             room,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tdt_pkg::TDATA_OUT_W-1:0]  m_tdata,   // token_code, token_line, token_offset, token_length
	output logic                             m_tlast    // last_of_run
);
	import tdt_pkg::*;

	localparam int PAD_W = TDATA_OUT_W - CODE_W - 2 * COUNT_W - LEN_W;

	result_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic             pop;
	result_t          head;

	assign pop  = m_tvalid && m_tready;
	assign room = cnt_q <= QCNT_W'(QUEUE_DEPTH - 2);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'b00) begin
			entry_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_q + QPTR_W'(1)] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.count);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	assign head     = entry_q[rd_q];
	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = {{PAD_W{1'b0}}, head.length, head.offset, head.line, head.code};
	assign m_tlast  = head.last;

endmodule

FILE: hdl/table_driven_dfa_tokenizer_unit.sv
// Top level of the table-driven longest-match DFA tokenizer.
// A scanned byte's tokens pass the request register, the row and token read, the transition
// read and the result queue on their way to the output.
// The engine takes a new scanned byte only once the current one retires, since its row read and
// transition read depend on the current state, and a byte retires only while the queue has room.
// Reset clears the scanner state, counters and the result queue; the tables are not
// cleared and must be loaded before scanning.
module table_driven_dfa_tokenizer_unit #(
	parameter int NUM_STATES       = tdt_pkg::NUM_STATES_DEF,
	parameter int TRANSITION_DEPTH = tdt_pkg::TRANSITION_DEPTH_DEF,
	parameter int TOKEN_BITS       = tdt_pkg::TOKEN_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tdt_pkg::ACTION_W-1:0]     s_tuser,   // action
	input  logic [tdt_pkg::TDATA_IN_W-1:0]   s_tdata,   // table_index, table_value, byte_value
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tdt_pkg::TDATA_OUT_W-1:0]  m_tdata,   // token_code, token_line, token_offset, token_length
	output logic                             m_tlast    // last_of_run
);
	import tdt_pkg::*;

	logic               take, item_valid, room;
	item_t              item;
	logic [CLASS_W-1:0] cls;
	push_t              push;

	// Request register and class lookup.
	tdt_front #(
		.NUM_STATES(NUM_STATES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.take       (take),
		.item_valid (item_valid),
		.item       (item),
		.cls        (cls)
	);

	// State stepping over the row and transition tables.
	tdt_engine #(
		.NUM_STATES      (NUM_STATES),
		.TRANSITION_DEPTH(TRANSITION_DEPTH),
		.TOKEN_BITS      (TOKEN_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.cls        (cls),
		.room       (room),
		.take       (take),
		.push       (push)
	);

	// Output buffering.
	tdt_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: hdl/tdt_checker.sv
// Port-level checks on the tokenizer output stream, bound to the top level.
module tdt_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [tdt_pkg::TDATA_OUT_W-1:0]  m_tdata,
	input  logic                             m_tlast
);
	import tdt_pkg::*;

	localparam int LEN_LO = CODE_W + 2 * COUNT_W;

	// The output queue is empty when reset is released.
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid straight after reset");

	// Both tokens of a byte are queued together, so a non-final one is followed at once.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("second token of a byte missing");

	// A zero-length token only comes from the start state and always closes its byte.
	a_zero_len_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[LEN_LO+LEN_W-1:LEN_LO] == '0 |-> m_tlast)
		else $error("zero-length token not last of its byte");

	// A stalled request holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output request changed while stalled");

endmodule

bind table_driven_dfa_tokenizer_unit tdt_checker u_tdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: bench/table_driven_dfa_tokenizer_unit_tb.sv
// Self-checking bench for the DFA tokenizer: loads and scans checked against a predictor.
module table_driven_dfa_tokenizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tdt_pkg::*;

	localparam int NSTATES     = NUM_STATES_DEF;
	localparam int TRANS_DEPTH = TRANSITION_DEPTH_DEF;
	localparam int IDLE_PCT    = 34;
	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 50;
	localparam int CYCLE_LIMIT  = 200000;

	// A lexeme that spans many bytes in one self-looping state.
	localparam int LONG_LEXEME = 120;
	localparam logic [BYTE_W-1:0] LOOP_BYTE   = 8'hA5;
	localparam logic [BYTE_W-1:0] BREAK_BYTE  = 8'h20;
	localparam int LOOP_CLASS  = 5;
	localparam int BREAK_CLASS = 6;
	localparam int LOOP_STATE  = 1;
	localparam int LOOP_ROW    = 100;

	localparam logic [VALUE_W-1:0] VALUE_MINUS_ONE = '1;
	localparam int MAX_ACTION = (1 << ACTION_W) - 1;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [INDEX_W-1:0]  index;
		logic [VALUE_W-1:0]  value;
		logic [BYTE_W-1:0]   chr;
	} lex_request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ACTION_W-1:0] s_tuser = '0;
	logic [TDATA_IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic m_tlast;

	// Two copies of the scanner: index 0 follows the stimulus as it is planned,
	// index 1 follows the requests as the block accepts them.
	logic [CLASS_W-1:0] char_class [2][CLASS_COUNT];
	logic [ROW_W-1:0]   row_base [2][NSTATES];
	logic [7:0]         next_state_tbl [2][TRANS_DEPTH];
	logic               token_ws [2][NSTATES];
	logic [CODE_W-1:0]  token_num [2][NSTATES];
	logic [7:0]         scan_state [2];
	logic [COUNT_W-1:0] line_count [2];
	logic [COUNT_W-1:0] byte_pos [2];
	logic [COUNT_W-1:0] lexeme_start [2];
	logic [COUNT_W-1:0] lexeme_line [2];

	// Entries loaded so far while planning; scans never read anything else.
	bit class_written [CLASS_COUNT];
	bit row_written [NSTATES];
	bit trans_written [TRANS_DEPTH];
	bit token_written [NSTATES];

	lex_request_t pending_requests[$];
	result_t      expected_tokens[$];
	lex_request_t in_flight;

	int accepted_count = 0;
	int scans_done = 0;
	int loads_done = 0;
	int tokens_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;

	logic [BYTE_W-1:0] alphabet [12] = '{8'h0A, 8'h20, 8'h41, 8'h42, 8'h43, 8'h61,
		8'h62, 8'h30, 8'h31, 8'h2B, 8'h28, 8'h29};

	// Stretches with no idling on either side.
	wire quiet = (accepted_count % 1000) >= 800;

	table_driven_dfa_tokenizer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Next state through the row-displaced transition table; out of range means none.
	function automatic logic [7:0] follow(int c, logic [7:0] st, logic [CLASS_W-1:0] cls);
		logic [SUM_W-1:0] addr;
		addr = {1'b0, row_base[c][st]} + {1'b0, cls};
		if (addr >= TRANS_DEPTH)
			return '0;
		return next_state_tbl[c][addr[INDEX_W-1:0]];
	endfunction

	function automatic void consume_byte(int c, logic [BYTE_W-1:0] chr, logic [7:0] st);
		if (chr == NEWLINE)
			line_count[c] = line_count[c] + 1;
		byte_pos[c] = byte_pos[c] + 1;
		scan_state[c] = st;
	endfunction

	// Builds the token of a state; whitespace tokens give nothing.
	function automatic bit make_token(int c, logic [7:0] st, logic [COUNT_W-1:0] line,
			logic [COUNT_W-1:0] off, logic [COUNT_W-1:0] span, output result_t tok);
		tok = '0;
		tok.code = token_num[c][st];
		tok.line = line;
		tok.offset = off;
		tok.length = (span > 32'hFFFF) ? 16'hFFFF : span[LEN_W-1:0];
		return !token_ws[c][st];
	endfunction

	// Applies one request to a scanner copy and returns the tokens it gives.
	function automatic int tokenize_request(int c, lex_request_t rq,
			output result_t first_tok, output result_t second_tok);
		result_t found [2];
		result_t tok;
		logic [CLASS_W-1:0] cls;
		logic [7:0] st;
		logic [7:0] nxt;
		bit done;
		int n;
		n = 0;
		done = 0;
		found[0] = '0;
		found[1] = '0;
		case (rq.act)
			ACT_LOAD_CLASS: begin
				if (rq.index < CLASS_COUNT)
					char_class[c][rq.index[7:0]] = rq.value[CLASS_W-1:0];
			end
			ACT_LOAD_ROW: begin
				if (rq.index < NSTATES)
					row_base[c][rq.index[7:0]] = rq.value[ROW_W-1:0];
			end
			ACT_LOAD_TRANS: begin
				// Non-positive values and multiples of the state count mean no transition.
				next_state_tbl[c][rq.index] = (rq.value[VALUE_W-1] || rq.value == '0) ?
					8'd0 : rq.value[7:0];
			end
			ACT_LOAD_TOKEN: begin
				if (rq.index < NSTATES) begin
					token_ws[c][rq.index[7:0]] = rq.value[VALUE_W-1];
					token_num[c][rq.index[7:0]] = rq.value[CODE_W-1:0];
				end
			end
			ACT_SCAN: begin
				cls = char_class[c][rq.chr];
				st = scan_state[c];
				nxt = follow(c, st, cls);
				if (nxt != 0) begin
					consume_byte(c, rq.chr, nxt);
					done = 1;
				end else if (st != 0) begin
					// The lexeme ends; the same byte restarts from the start state.
					if (make_token(c, st, lexeme_line[c], lexeme_start[c],
							byte_pos[c] - lexeme_start[c], tok)) begin
						found[n] = tok;
						n = n + 1;
					end
					scan_state[c] = '0;
					lexeme_start[c] = byte_pos[c];
					lexeme_line[c] = line_count[c];
					nxt = follow(c, 8'd0, cls);
					if (nxt != 0) begin
						consume_byte(c, rq.chr, nxt);
						done = 1;
					end
				end
				if (!done) begin
					// No way out of the start state: zero-length token, byte consumed.
					if (make_token(c, 8'd0, line_count[c], byte_pos[c], '0, tok)) begin
						found[n] = tok;
						n = n + 1;
					end
					consume_byte(c, rq.chr, 8'd0);
					lexeme_start[c] = byte_pos[c];
					lexeme_line[c] = line_count[c];
				end
				if (n > 0)
					found[n-1].last = 1'b1;
			end
			default: ;
		endcase
		first_tok = found[0];
		second_tok = found[1];
		return n;
	endfunction

	// Row and transition entries that leaving state st on class cls would read.
	function automatic bit path_gap(logic [7:0] st, logic [CLASS_W-1:0] cls,
			output logic [ACTION_W-1:0] act, output int idx);
		logic [SUM_W-1:0] addr;
		act = ACT_LOAD_ROW;
		idx = st;
		if (!row_written[st])
			return 1;
		addr = {1'b0, row_base[0][st]} + {1'b0, cls};
		act = ACT_LOAD_TRANS;
		idx = addr;
		return addr < TRANS_DEPTH && !trans_written[addr[INDEX_W-1:0]];
	endfunction

	// First entry a scan of chr would read before it has been loaded, if any.
	function automatic bit find_gap(logic [BYTE_W-1:0] chr,
			output logic [ACTION_W-1:0] act, output int idx);
		logic [CLASS_W-1:0] cls;
		logic [7:0] st;
		act = ACT_LOAD_CLASS;
		idx = chr;
		if (!class_written[chr])
			return 1;
		cls = char_class[0][chr];
		st = scan_state[0];
		if (path_gap(st, cls, act, idx))
			return 1;
		if (follow(0, st, cls) != 0)
			return 0;
		if (st != 0) begin
			act = ACT_LOAD_TOKEN;
			idx = st;
			if (!token_written[st])
				return 1;
			if (path_gap(8'd0, cls, act, idx))
				return 1;
			if (follow(0, 8'd0, cls) != 0)
				return 0;
		end
		act = ACT_LOAD_TOKEN;
		idx = 0;
		return !token_written[0];
	endfunction

	// Table contents that give a small language with lexemes of a few bytes.
	function automatic int fill_value(logic [ACTION_W-1:0] act);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (act)
			ACT_LOAD_CLASS:
				fill_value = (roll < 85) ? $urandom_range(0, 7) :
					(roll < 95) ? $urandom_range(0, 4095) : int'(VALUE_MINUS_ONE);
			ACT_LOAD_ROW:
				fill_value = (roll < 80) ? $urandom_range(0, 3000) :
					(roll < 95) ? $urandom_range(3001, 4095) : int'(VALUE_MINUS_ONE);
			ACT_LOAD_TRANS:
				fill_value = (roll < 10) ? int'(VALUE_MINUS_ONE) : (roll < 20) ? 0 :
					(roll < 30) ? 256 * $urandom_range(1, 15) :
					256 * $urandom_range(0, 15) + $urandom_range(1, 12);
			ACT_LOAD_TOKEN:
				fill_value = (roll < 25) ? int'(VALUE_MINUS_ONE) : $urandom_range(0, 4095);
			default:
				fill_value = 0;
		endcase
	endfunction

	task automatic store_request(int act, int idx, int val, int chr);
		lex_request_t rq;
		result_t t0;
		result_t t1;
		rq.act = ACTION_W'(act);
		rq.index = INDEX_W'(idx);
		rq.value = VALUE_W'(val);
		rq.chr = BYTE_W'(chr);
		pending_requests.push_back(rq);
		case (rq.act)
			ACT_LOAD_CLASS: if (rq.index < CLASS_COUNT) class_written[rq.index[7:0]] = 1;
			ACT_LOAD_ROW:   if (rq.index < NSTATES) row_written[rq.index[7:0]] = 1;
			ACT_LOAD_TRANS: trans_written[rq.index] = 1;
			ACT_LOAD_TOKEN: if (rq.index < NSTATES) token_written[rq.index[7:0]] = 1;
			default: ;
		endcase
		void'(tokenize_request(0, rq, t0, t1));
	endtask

	// Queues a request, first loading whatever entries a scan would otherwise read unset.
	task automatic plan_request(int act, int idx, int val, int chr);
		logic [ACTION_W-1:0] gap_act;
		int gap_idx;
		if (act == ACT_SCAN) begin
			while (find_gap(BYTE_W'(chr), gap_act, gap_idx))
				store_request(gap_act, gap_idx, fill_value(gap_act), $urandom_range(0, 255));
		end
		store_request(act, idx, val, chr);
	endtask

	task automatic compare_field(string what, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: token %0d %s mismatch: expected %0d, actual %0d",
				$time, tokens_checked, what, want, got);
			mismatches++;
		end
	endtask

	// Request driver: presents queued requests, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		result_t t0;
		result_t t1;
		int n;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser <= ACT_LOAD_CLASS;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				n = tokenize_request(1, in_flight, t0, t1);
				if (n > 0)
					expected_tokens.push_back(t0);
				if (n > 1)
					expected_tokens.push_back(t1);
				if (in_flight.act == ACT_SCAN)
					scans_done++;
				else if (in_flight.act < ACT_SCAN)
					loads_done++;
				accepted_count <= accepted_count + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 &&
						(quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_flight = pending_requests.pop_front();
					s_tuser <= in_flight.act;
					s_tdata <= {{(TDATA_IN_W-INDEX_W-VALUE_W-BYTE_W){1'b0}},
						in_flight.chr, in_flight.value, in_flight.index};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Token monitor: random back-pressure and a field-by-field check.
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '0;
				got.code = m_tdata[0 +: CODE_W];
				got.line = m_tdata[CODE_W +: COUNT_W];
				got.offset = m_tdata[CODE_W+COUNT_W +: COUNT_W];
				got.length = m_tdata[CODE_W+2*COUNT_W +: LEN_W];
				got.last = m_tlast;
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected token: expected none, actual code %0d line %0d %s",
						$time, got.code, got.line,
						$sformatf("offset %0d length %0d last %0d",
							got.offset, got.length, got.last));
					mismatches++;
				end else begin
					want = expected_tokens.pop_front();
					compare_field("code", want.code, got.code);
					compare_field("line", want.line, got.line);
					compare_field("offset", want.offset, got.offset);
					compare_field("length", want.length, got.length);
					compare_field("last", want.last, got.last);
				end
				tokens_checked++;
			end
			m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d requests and %0d tokens outstanding.",
				cycle_count, pending_requests.size(), expected_tokens.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus plan, reset and end of run.
	initial begin
		int random_items;
		int roll;
		int idx;
		logic [ACTION_W-1:0] act;
		logic [BYTE_W-1:0] chr;
		for (int c = 0; c < 2; c++) begin
			scan_state[c] = '0;
			line_count[c] = '0;
			byte_pos[c] = '0;
			lexeme_start[c] = '0;
			lexeme_line[c] = '0;
		end

		// A self-looping state that builds one long lexeme.
		plan_request(ACT_LOAD_CLASS, LOOP_BYTE, LOOP_CLASS, 8'h00);
		plan_request(ACT_LOAD_CLASS, BREAK_BYTE, BREAK_CLASS, 8'h00);
		plan_request(ACT_LOAD_ROW, 0, 0, 8'h00);
		plan_request(ACT_LOAD_ROW, LOOP_STATE, LOOP_ROW, 8'h00);
		plan_request(ACT_LOAD_TRANS, LOOP_CLASS, LOOP_STATE, 8'h00);
		plan_request(ACT_LOAD_TRANS, LOOP_ROW + LOOP_CLASS, LOOP_STATE, 8'h00);
		plan_request(ACT_LOAD_TRANS, LOOP_ROW + BREAK_CLASS, 0, 8'h00);
		plan_request(ACT_LOAD_TOKEN, LOOP_STATE, 1023, 8'h00);
		for (int i = 0; i < LONG_LEXEME; i++)
			plan_request(ACT_SCAN, 0, 0, LOOP_BYTE);
		plan_request(ACT_SCAN, 0, 0, BREAK_BYTE);

		// Field extremes, ignored indexes, value folding and unused actions.
		plan_request(ACT_LOAD_CLASS, 255, 4095, 8'h00);
		plan_request(ACT_LOAD_CLASS, 256, 3, 8'h00);
		plan_request(ACT_LOAD_CLASS, 4095, VALUE_MINUS_ONE, 8'hFF);
		plan_request(ACT_LOAD_ROW, 255, VALUE_MINUS_ONE, 8'h00);
		plan_request(ACT_LOAD_ROW, 4095, 0, 8'h00);
		plan_request(ACT_LOAD_TRANS, 4095, 4095, 8'h00);
		plan_request(ACT_LOAD_TRANS, 4094, VALUE_MINUS_ONE, 8'h00);
		plan_request(ACT_LOAD_TRANS, 0, 256, 8'h00);
		plan_request(ACT_LOAD_TOKEN, 255, VALUE_MINUS_ONE, 8'h00);
		plan_request(ACT_LOAD_TOKEN, 0, 4095, 8'h00);
		plan_request(ACT_LOAD_TOKEN, 4095, 7, 8'h00);
		for (int a = ACT_SCAN + 1; a <= MAX_ACTION; a++)
			plan_request(a, 4095, VALUE_MINUS_ONE, 8'hFF);
		plan_request(ACT_SCAN, 0, 0, 8'hFF);
		plan_request(ACT_SCAN, 0, 0, NEWLINE);
		plan_request(ACT_SCAN, 0, 0, 8'h00);
		plan_request(ACT_SCAN, 0, 0, BREAK_BYTE);
		plan_request(ACT_SCAN, 0, 0, NEWLINE);
		// A whitespace start-state token is dropped, then reporting resumes.
		plan_request(ACT_LOAD_TOKEN, 0, VALUE_MINUS_ONE, 8'h00);
		plan_request(ACT_SCAN, 0, 0, 8'hFF);
		plan_request(ACT_LOAD_TOKEN, 0, 4095, 8'h00);
		plan_request(ACT_SCAN, 0, 0, 8'hFF);

		// Mostly scans over a small alphabet, with table rewrites and noise.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				chr = ($urandom_range(0, 9) != 0) ? alphabet[$urandom_range(0, 11)] :
					BYTE_W'($urandom_range(0, 255));
				plan_request(ACT_SCAN, $urandom_range(0, 4095), $urandom_range(0, 8191), chr);
				random_items++;
			end else if (roll < 95) begin
				act = ACTION_W'($urandom_range(ACT_LOAD_CLASS, ACT_LOAD_TOKEN));
				roll = $urandom_range(0, 99);
				if (act == ACT_LOAD_TRANS)
					idx = $urandom_range(0, 4095);
				else if (roll < 15)
					idx = $urandom_range(256, 4095);
				else if (act == ACT_LOAD_CLASS && roll < 60)
					idx = alphabet[$urandom_range(0, 11)];
				else if (roll < 55)
					idx = $urandom_range(0, 15);
				else
					idx = $urandom_range(0, 255);
				plan_request(act, idx, fill_value(act), $urandom_range(0, 255));
				random_items++;
			end else begin
				plan_request($urandom_range(ACT_SCAN + 1, MAX_ACTION), $urandom_range(0, 4095),
					$urandom_range(0, 8191), $urandom_range(0, 255));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Scanned %0d bytes and applied %0d table loads; %0d tokens compared.",
			scans_done, loads_done, tokens_checked);
		$display("Included one lexeme of %0d bytes, whitespace drops and dead-end bytes.",
			LONG_LEXEME);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches found.", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
